[rtl/teq_pkg.sv]
// ----------------------------------------------------------------------------
// teq_pkg
// shared constants, codes and control/status types of the timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int HANDLE_BITS = 8;
	localparam int TAG_BITS    = 16;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REM_H  = 3'd1,
		CMD_REM_HT = 3'd2,
		CMD_QUERY  = 3'd3,
		CMD_ACT    = 3'd4,
		CMD_PAUSE  = 3'd5,
		CMD_RESUME = 3'd6,
		CMD_CLEAR  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADJ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0]            due;
		logic [HANDLE_BITS-1:0] handle;
		logic [TAG_BITS-1:0]    tag;
		logic                   alw;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic ptr_inc;
		logic ins;
		logic drop;
		logic adj;
		logic res_plain;
		logic res_found;
		logic res_delay;
		logic res_full;
		logic res_fire;
		logic res_last;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd_in;
		cmd_t cmd;
		logic at_end;
		logic due_lt;
		logic now_lt;
		logic match;
		logic fire_ok;
		logic nfired_max;
		logic full;
		logic adj_needed;
		logic last;
	} sts_t;

endpackage

[rtl/teq_req_if.sv]
// ----------------------------------------------------------------------------
// teq_req_if
// command channel of the timed event queue
// ----------------------------------------------------------------------------
interface teq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [31:0] now;
	logic [31:0] due_time;
	logic [7:0]  handle;
	logic [15:0] tag;
	logic        always_req;

	modport source (output valid, command, now, due_time, handle, tag, always_req,
		input ready);
	modport sink (input valid, command, now, due_time, handle, tag, always_req,
		output ready);
endinterface

[rtl/teq_rsp_if.sv]
// ----------------------------------------------------------------------------
// teq_rsp_if
// result channel of the timed event queue
// ----------------------------------------------------------------------------
interface teq_rsp_if;
	logic        valid;
	logic        ready;
	logic        fired;
	logic [7:0]  event_handle;
	logic [15:0] event_tag;
	logic        found;
	logic [30:0] delay;
	logic        full_res;
	logic        last;

	modport source (output valid, fired, event_handle, event_tag, found, delay,
		full_res, last, input ready);
	modport sink (input valid, fired, event_handle, event_tag, found, delay,
		full_res, last, output ready);
endinterface

[rtl/timed_event_queue.sv]
// ----------------------------------------------------------------------------
// timed_event_queue
// time-sorted queue of timer events with nested pause and resume
// ----------------------------------------------------------------------------
// usage
//   req carries one command item: add, remove by handle, remove by handle
//   and tag, query delay, activate, pause, resume or clear
//   rsp returns the result items; every command gives one item, activate
//   gives one per fired event (at most 16) or a single idle item, and the
//   final item of a command has last set
//   one command is worked at a time; req.ready is high only while idle
//   the slot scan visits one entry per cycle while no result item waits;
//   add, remove and query scan up to their position, activate fires,
//   looks ahead and hands out each fired event and skips entries that
//   may not fire, the final resume walks every entry, and pause and
//   clear need no scan; each waits on rsp.ready for its results
//   a stall on rsp holds the result item and the whole block
//   reset empties the queue and leaves the pause state cleared
// ----------------------------------------------------------------------------
module timed_event_queue import teq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	teq_req_if.sink  req,
	teq_rsp_if.source rsp
);

	// command and status between sequencer and datapath
	ctl_t ctl;
	sts_t sts;

	teq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// slot row, pause state and the result register
	teq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.in_command   (req.command),
		.in_now       (req.now),
		.in_due_time  (req.due_time),
		.in_handle    (req.handle),
		.in_tag       (req.tag),
		.in_always    (req.always_req),
		.fired        (rsp.fired),
		.event_handle (rsp.event_handle),
		.event_tag    (rsp.event_tag),
		.found        (rsp.found),
		.delay        (rsp.delay),
		.full_res     (rsp.full_res),
		.last         (rsp.last)
	);

	// a result item is never shown while a new command may enter
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("result shown while taking a command");

	// only activate hands out events
	a_fire_act: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.fired) |-> (sts.cmd == CMD_ACT))
		else $error("event fired outside activate");

	// a non-final result is followed by more work, not by idle
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !rsp.last) |=> !req.ready)
		else $error("command ended before its final result");

endmodule

[rtl/teq_datapath.sv]
// ----------------------------------------------------------------------------
// teq_datapath
// event slots, scan pointer, pause state and the result register
// ----------------------------------------------------------------------------
module teq_datapath import teq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic [2:0]  in_command,
	input  logic [31:0] in_now,
	input  logic [31:0] in_due_time,
	input  logic [7:0]  in_handle,
	input  logic [15:0] in_tag,
	input  logic        in_always,
	output logic        fired,
	output logic [7:0]  event_handle,
	output logic [15:0] event_tag,
	output logic        found,
	output logic [30:0] delay,
	output logic        full_res,
	output logic        last
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [FIRE_W-1:0]   nfired_q;
	logic [7:0]          pause_depth_q;
	logic [31:0]         pause_start_q;
	logic [31:0]         diff_q;
	cmd_t                cmd_q;
	logic [31:0]         now_q;
	entry_t              new_q;

	logic [IDX_W-1:0]    idx;
	entry_t              cur;
	logic                paused;
	logic [31:0]         in_elapsed;
	logic [31:0]         qdiff;
	logic [31:0]         ref_time;

	assign idx        = ptr_q[IDX_W-1:0];
	assign cur        = slot_q[idx];
	assign paused     = (pause_depth_q != 8'd0);
	assign in_elapsed = in_now - pause_start_q;
	assign ref_time   = paused ? pause_start_q : now_q;
	assign qdiff      = cur.due - ref_time;

	always_comb begin
		sts.cmd_in     = cmd_t'(in_command);
		sts.cmd        = cmd_q;
		sts.at_end     = (ptr_q == count_q);
		sts.due_lt     = (new_q.due < cur.due);
		sts.now_lt     = (now_q < cur.due);
		sts.match      = (cur.handle == new_q.handle) &&
			((cmd_q != CMD_REM_HT) || (cur.tag == new_q.tag));
		sts.fire_ok    = !paused || cur.alw;
		sts.nfired_max = (nfired_q == FIRE_W'(MAX_RESULTS));
		sts.full       = (count_q == CNT_W'(QUEUE_DEPTH));
		sts.adj_needed = (cmd_t'(in_command) == CMD_RESUME) &&
			(pause_depth_q == 8'd1) && !in_elapsed[31];
		sts.last       = last;
	end

	// latched command, scan pointer, counters and pause bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			ptr_q         <= '0;
			nfired_q      <= '0;
			pause_depth_q <= '0;
			pause_start_q <= '0;
			cmd_q         <= CMD_ADD;
		end else begin
			if (ctl.load) begin
				cmd_q    <= cmd_t'(in_command);
				ptr_q    <= '0;
				nfired_q <= '0;
				case (cmd_t'(in_command))
					CMD_PAUSE: begin
						if (!paused)
							pause_start_q <= in_now;
						if (pause_depth_q != 8'hff)
							pause_depth_q <= pause_depth_q + 8'd1;
					end
					CMD_RESUME: begin
						if (paused) begin
							pause_depth_q <= pause_depth_q - 8'd1;
							if (pause_depth_q == 8'd1)
								pause_start_q <= '0;
						end
					end
					CMD_CLEAR: count_q <= '0;
					default: ;
				endcase
			end else begin
				if (ctl.ptr_inc)
					ptr_q <= ptr_q + CNT_W'(1);
				if (ctl.ins)
					count_q <= count_q + CNT_W'(1);
				else if (ctl.drop)
					count_q <= count_q - CNT_W'(1);
				if (ctl.res_fire)
					nfired_q <= nfired_q + FIRE_W'(1);
			end
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			now_q      <= in_now;
			diff_q     <= in_elapsed;
			new_q.due  <= (paused && !in_always) ? in_due_time - in_elapsed : in_due_time;
			new_q.handle <= HANDLE_BITS'(in_handle);
			new_q.tag  <= TAG_BITS'(in_tag);
			new_q.alw  <= in_always;
		end
	end

	// slot row: insert and drop shift the entries from the pointer on from a neighbor, adjust moves one due time
	always_ff @(posedge clk) begin
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			if (ctl.ins) begin
				if (CNT_W'(j) == ptr_q)
					slot_q[j] <= new_q;
				else if (j > 0 && CNT_W'(j) > ptr_q)
					slot_q[j] <= slot_q[(j > 0) ? j - 1 : 0];
			end else if (ctl.drop) begin
				if (j < QUEUE_DEPTH - 1 && CNT_W'(j) >= ptr_q)
					slot_q[j] <= slot_q[(j < QUEUE_DEPTH - 1) ? j + 1 : j];
			end
		end
		if (ctl.adj && !cur.alw)
			slot_q[idx].due <= cur.due + diff_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.res_plain) begin
			fired        <= 1'b0;
			event_handle <= '0;
			event_tag    <= '0;
			found        <= ctl.res_found;
			delay        <= (ctl.res_delay && !qdiff[31]) ? qdiff[30:0] : '0;
			full_res     <= ctl.res_full;
			last         <= 1'b1;
		end else if (ctl.res_fire) begin
			fired        <= 1'b1;
			event_handle <= 8'(cur.handle);
			event_tag    <= 16'(cur.tag);
			found        <= 1'b0;
			delay        <= '0;
			full_res     <= 1'b0;
			last         <= 1'b0;
		end else if (ctl.res_last) begin
			last <= 1'b1;
		end
	end

endmodule

[rtl/teq_ctrl.sv]
// ----------------------------------------------------------------------------
// teq_ctrl
// command sequencer of the timed event queue
// ----------------------------------------------------------------------------
module teq_ctrl import teq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.cmd_in)
						CMD_ADD:    state_d = sts.full ? ST_OUT : ST_SCAN;
						CMD_PAUSE,
						CMD_CLEAR:  state_d = ST_OUT;
						CMD_RESUME: state_d = sts.adj_needed ? ST_ADJ : ST_OUT;
						default:    state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				case (sts.cmd)
					CMD_ADD: if (sts.at_end || sts.due_lt) state_d = ST_OUT;
					CMD_ACT: begin
						if (sts.at_end || sts.now_lt || sts.nfired_max) begin
							state_d = ST_OUT;
							pend_d  = 1'b0;
						end else if (sts.fire_ok) begin
							if (pend_q) begin
								state_d = ST_OUT;
								pend_d  = 1'b0;
							end else begin
								pend_d = 1'b1;
							end
						end
					end
					default: if (sts.at_end || sts.match) state_d = ST_OUT;
				endcase
			end
			ST_ADJ: if (sts.at_end) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = sts.last ? ST_IDLE : ST_SCAN;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					case (sts.cmd_in)
						CMD_ADD: if (sts.full) begin
							ctl.res_plain = 1'b1;
							ctl.res_full  = 1'b1;
						end
						CMD_PAUSE,
						CMD_CLEAR:  ctl.res_plain = 1'b1;
						CMD_RESUME: ctl.res_plain = !sts.adj_needed;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				case (sts.cmd)
					CMD_ADD: begin
						if (sts.at_end || sts.due_lt) begin
							ctl.ins       = 1'b1;
							ctl.res_plain = 1'b1;
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
					CMD_ACT: begin
						if (sts.at_end || sts.now_lt || sts.nfired_max) begin
							ctl.res_last  = pend_q;
							ctl.res_plain = !pend_q;
						end else if (sts.fire_ok) begin
							if (!pend_q) begin
								ctl.res_fire = 1'b1;
								ctl.drop     = 1'b1;
							end
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
					default: begin
						if (sts.at_end) begin
							ctl.res_plain = 1'b1;
						end else if (sts.match) begin
							ctl.res_plain = 1'b1;
							ctl.res_found = 1'b1;
							ctl.res_delay = (sts.cmd == CMD_QUERY);
							ctl.drop      = (sts.cmd != CMD_QUERY);
						end else begin
							ctl.ptr_inc = 1'b1;
						end
					end
				endcase
			end
			ST_ADJ: begin
				if (sts.at_end) begin
					ctl.res_plain = 1'b1;
				end else begin
					ctl.adj     = 1'b1;
					ctl.ptr_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
